@@ rtl/core/assert_macros.svh @@
// Assertion helpers for RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held.
`define ACT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ACT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/act_pkg.sv @@
`timescale 1ns / 1ps

package act_pkg;

    // Default build values
    localparam int MAX_EVENTS_DEF    = 64;
    localparam int EPSILON_UNITS_DEF = 66;

    // Datapath widths
    localparam int ACC_W = 40;   // phase accumulator
    localparam int CMP_W = 41;   // accumulator compares and sums
    localparam int DLY_W = 34;   // start delay countdown

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_AT_END  = 3'd4;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_PLAY   = 2'd1,
        KIND_RESUME = 2'd2,
        KIND_STOP   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        EV_STATUS = 2'd0,
        EV_START  = 2'd1,
        EV_CYCLE  = 2'd2,
        EV_END    = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ADD,
        S_WRAP,
        S_END
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CMD,
        OP_DELAY,
        OP_MUL,
        OP_ADD,
        OP_WRAP,
        OP_END
    } t_dp_op;

    // Controller to datapath
    typedef struct packed {
        logic   capture;
        t_dp_op op;
        logic   out_load;
        t_event out_ev;
        logic   out_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  halted;
        logic  delay_pending;
        logic  delay_done;
        logic  ge_thr;
        logic  ge_thr2;
        logic  end_hit;
        logic  out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/act_ctrl.sv @@
`timescale 1ns / 1ps

module act_ctrl
    import act_pkg::*;
#(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(MAX_EVENTS);
    localparam logic [CNT_W-1:0] MORE_LIM = CNT_W'(MAX_EVENTS - 2);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic             w_cycle_last;

    // A cycle beat is final unless an end follows or another wrap fits
    assign w_cycle_last = !i_sts.end_hit && !((r_n < MORE_LIM) && i_sts.ge_thr2);

    assign o_in_ready = (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.kind == KIND_TICK && !i_sts.halted && !i_sts.delay_pending) begin
                    n_state = S_ADD;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: n_state = S_WRAP;
            S_WRAP: begin
                if (i_sts.out_free) begin
                    if (!i_sts.ge_thr) n_state = S_IDLE;
                    else if (i_sts.end_hit) n_state = S_END;
                    else if (w_cycle_last) n_state = S_IDLE;
                end
            end
            S_END: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.out_ev   = EV_STATUS;
        n_n            = r_n;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                n_n           = '0;
            end
            S_EXEC: begin
                if (i_sts.kind != KIND_TICK) begin
                    if (i_sts.out_free) begin
                        o_cmd.op       = OP_CMD;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = 1'b1;
                    end
                end else if (i_sts.halted) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = 1'b1;
                    end
                end else if (i_sts.delay_pending) begin
                    if (i_sts.out_free) begin
                        o_cmd.op       = OP_DELAY;
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_last = 1'b1;
                        o_cmd.out_ev   = i_sts.delay_done ? EV_START : EV_STATUS;
                    end
                end else begin
                    o_cmd.op = OP_MUL;
                end
            end
            S_ADD: o_cmd.op = OP_ADD;
            S_WRAP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.ge_thr) begin
                        o_cmd.op       = OP_WRAP;
                        o_cmd.out_ev   = EV_CYCLE;
                        o_cmd.out_last = w_cycle_last;
                        n_n            = r_n + CNT_W'(1);
                    end else begin
                        o_cmd.out_last = 1'b1;
                    end
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.op       = OP_END;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ev   = EV_END;
                    o_cmd.out_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
        end
    end

endmodule

@@ rtl/core/act_dp.sv @@
`timescale 1ns / 1ps

module act_dp
    import act_pkg::*;
#(
    parameter int EPSILON_UNITS = EPSILON_UNITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [1:0]            i_kind,
    input  logic [15:0]           i_elapsed,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_event_res,
    output logic [15:0]           o_cycle_number,
    output logic                  o_is_paused,
    output logic                  o_is_stopped,
    output logic                  o_last
);

    localparam logic signed [CMP_W-1:0] EPS_C = CMP_W'(EPSILON_UNITS);
    localparam logic signed [DLY_W-1:0] EPS_D = DLY_W'(EPSILON_UNITS);
    localparam logic signed [CMP_W-1:0] ACC_MAX = CMP_W'((64'd1 << (ACC_W - 1)) - 64'd1);

    // Configuration
    logic        [31:0] r_cycle_length;
    logic        [15:0] r_speed_gain;
    logic        [31:0] r_start_delay;
    logic signed [15:0] r_cycle_limit;
    logic               r_halt_at_end;

    // Timer state
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [DLY_W-1:0] r_delay, n_delay;
    logic        [15:0]      r_cnt, n_cnt;
    logic                    r_paused, n_paused;
    logic                    r_stopped, n_stopped;

    // Item and per-tick working registers
    t_kind                   r_kind;
    logic        [15:0]      r_elapsed;
    logic        [23:0]      r_prod;
    logic signed [CMP_W-1:0] r_thr;
    logic signed [CMP_W-1:0] r_thr2;

    // Output beat
    logic        r_out_valid;
    t_event      r_out_ev;
    logic [15:0] r_out_cnt;
    logic        r_out_paused;
    logic        r_out_stopped;
    logic        r_out_last;

    logic signed [CMP_W-1:0] w_acc_x, w_len_x, w_sum, w_wrap;
    logic signed [DLY_W-1:0] w_delay_sub;
    logic        [15:0]      w_cnt_inc;
    logic                    w_end_hit;

    assign w_acc_x     = CMP_W'(r_acc);
    assign w_len_x     = $signed({{(CMP_W - 32){1'b0}}, r_cycle_length});
    assign w_sum       = w_acc_x + $signed({{(CMP_W - 24){1'b0}}, r_prod});
    assign w_wrap      = w_acc_x - w_len_x;
    assign w_delay_sub = r_delay - $signed({{(DLY_W - 16){1'b0}}, r_elapsed});
    assign w_cnt_inc   = r_cnt + 16'd1;
    assign w_end_hit   = !r_cycle_limit[15] && (r_cycle_limit != 16'sd0)
                         && (w_cnt_inc >= $unsigned(r_cycle_limit));

    // Status to the controller
    always_comb begin
        o_sts.kind          = r_kind;
        o_sts.halted        = r_paused | r_stopped;
        o_sts.delay_pending = r_delay > EPS_D;
        o_sts.delay_done    = w_delay_sub <= EPS_D;
        o_sts.ge_thr        = w_acc_x >= r_thr;
        o_sts.ge_thr2       = w_acc_x >= r_thr2;
        o_sts.end_hit       = w_end_hit;
        o_sts.out_free      = !r_out_valid || i_out_ready;
    end

    // Next timer state per operation, then register writes
    always_comb begin
        n_acc     = r_acc;
        n_delay   = r_delay;
        n_cnt     = r_cnt;
        n_paused  = r_paused;
        n_stopped = r_stopped;
        case (i_cmd.op)
            OP_CMD: begin
                case (r_kind)
                    KIND_PLAY: begin
                        n_acc     = '0;
                        n_cnt     = '0;
                        n_delay   = $signed({{(DLY_W - 32){1'b0}}, r_start_delay});
                        n_paused  = 1'b0;
                        n_stopped = 1'b0;
                    end
                    KIND_RESUME: begin
                        n_paused  = 1'b0;
                        n_stopped = 1'b0;
                    end
                    KIND_STOP: n_stopped = 1'b1;
                    default: ;
                endcase
            end
            OP_DELAY: n_delay = w_delay_sub;
            OP_ADD:   n_acc   = (w_sum > ACC_MAX) ? ACC_W'(ACC_MAX) : ACC_W'(w_sum);
            OP_WRAP: begin
                n_acc = ACC_W'(w_wrap);
                n_cnt = w_cnt_inc;
            end
            OP_END: begin
                n_acc     = ACC_W'(w_len_x);
                n_paused  = 1'b1;
                n_stopped = r_stopped | r_halt_at_end;
            end
            default: ;
        endcase
        if (i_cfg_we && i_cfg_index == CFG_CYCLE_LIMIT) begin
            n_cnt = '0;
            if (i_cfg_data[15:0] == 16'd0) n_paused = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_delay   <= '0;
            r_cnt     <= '0;
            r_paused  <= 1'b0;
            r_stopped <= 1'b1;
        end else begin
            r_acc     <= n_acc;
            r_delay   <= n_delay;
            r_cnt     <= n_cnt;
            r_paused  <= n_paused;
            r_stopped <= n_stopped;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_length <= 32'd65536;
            r_speed_gain   <= 16'd256;
            r_start_delay  <= 32'd0;
            r_cycle_limit  <= -16'sd1;
            r_halt_at_end  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CYCLE_LENGTH: r_cycle_length <= i_cfg_data;
                CFG_SPEED_GAIN:   r_speed_gain   <= i_cfg_data[15:0];
                CFG_START_DELAY:  r_start_delay  <= i_cfg_data;
                CFG_CYCLE_LIMIT:  r_cycle_limit  <= $signed(i_cfg_data[15:0]);
                CFG_HALT_AT_END:  r_halt_at_end  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture the item, scale the tick and set up the wrap thresholds
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= t_kind'(i_kind);
            r_elapsed <= i_elapsed;
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= 24'((32'(r_speed_gain) * 32'(r_elapsed)) >> 8);
            r_thr  <= w_len_x - EPS_C;
            r_thr2 <= (w_len_x <<< 1) - EPS_C;
        end
    end

    // Output register: load a beat, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ev      <= i_cmd.out_ev;
            r_out_cnt     <= n_cnt;
            r_out_paused  <= n_paused;
            r_out_stopped <= n_stopped;
            r_out_last    <= i_cmd.out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out_ev;
    assign o_cycle_number = r_out_cnt;
    assign o_is_paused    = r_out_paused;
    assign o_is_stopped   = r_out_stopped;
    assign o_last         = r_out_last;

endmodule

@@ rtl/core/animation_cycle_timer.sv @@
`timescale 1ns / 1ps
// Animation cycle timer.
// Input channel (i_in_valid / o_in_ready) takes one command beat: kind 0 tick
// with i_elapsed, 1 play, 2 resume, 3 stop. Output channel (o_out_valid /
// i_out_ready) returns one or more result beats per command; o_last marks the
// final one. Configuration (i_cfg_valid / o_cfg_ready) writes a register by
// index and is always ready; write only while the timer is idle.
// A command, or a tick that is paused, stopped or counting down its start
// delay, is captured and its single beat is then loaded into the output
// register once that is free. A running tick multiplies, adds and then
// unrolls cycle wraps: its first beat follows the multiply and add steps,
// then one beat per cycle while the receiver takes them, up to MAX_EVENTS
// beats. The wrap loop does one subtract per cycle. The next item is
// accepted the cycle after its predecessor's last beat is loaded into the
// output register, even while that beat still waits. When the receiver
// stalls, the output register holds its beat and the wrap loop waits. Reset
// loads default configuration and leaves the timer stopped with a cleared
// accumulator and count.

module animation_cycle_timer
    import act_pkg::*;
#(
    parameter int MAX_EVENTS    = MAX_EVENTS_DEF,
    parameter int EPSILON_UNITS = EPSILON_UNITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic [15:0]           i_elapsed,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_event_res,
    output logic [15:0]           o_cycle_number,
    output logic                  o_is_paused,
    output logic                  o_is_stopped,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    act_ctrl #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    act_dp #(
        .EPSILON_UNITS (EPSILON_UNITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_elapsed      (i_elapsed),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_cycle_number (o_cycle_number),
        .o_is_paused    (o_is_paused),
        .o_is_stopped   (o_is_stopped),
        .o_last         (o_last)
    );

    // Never load a beat while the input side is open
    `ACT_ASSERT(a_no_load_idle, i_clk, i_rst_n, (o_in_ready |-> !w_cmd.out_load), "load while idle")
    // Never overwrite a beat that has not been taken
    `ACT_ASSERT(a_load_free, i_clk, i_rst_n, (w_cmd.out_load |-> w_sts.out_free), "beat overwritten")
    // After the last beat of an item, open the input side
    `ACT_ASSERT(a_last_idle, i_clk, i_rst_n, ((w_cmd.out_load && w_cmd.out_last) |=> o_in_ready), "no return to idle")

endmodule
